FILE: hw/rtl/qdva_pkg.sv
// Shared types, constants and the quadrature transition table for the
// detent value adjuster. No dependencies.
package qdva_pkg;

   localparam int unsigned DataWidth   = 16;
   localparam int unsigned GapWidth    = 8;
   localparam int unsigned TimeWidth   = 32;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CountWidth  = 4;
   localparam int unsigned DefaultDetentTransitions = 4;

   localparam logic [DataWidth-1:0] StepReset  = 16'd10;
   localparam logic [DataWidth-1:0] MinReset   = 16'd0;
   localparam logic [DataWidth-1:0] MaxReset   = 16'hFFFF;
   localparam logic [GapWidth-1:0]  GapReset   = 8'd1;
   localparam logic [DataWidth-1:0] StartReset = 16'd100;
   localparam logic [1:0]           PinsReset  = 2'b11;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_ADJUST_MODE  = 3'd0,
      REG_STEP_MS      = 3'd1,
      REG_MIN_MS       = 3'd2,
      REG_MAX_MS       = 3'd3,
      REG_EVENT_GAP_MS = 3'd4,
      REG_START_ON_MS  = 3'd5,
      REG_START_OFF_MS = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                 adjust_mode;
      logic [DataWidth-1:0] step_ms;
      logic [DataWidth-1:0] min_ms;
      logic [DataWidth-1:0] max_ms;
      logic [GapWidth-1:0]  event_gap_ms;
      logic                 load_on;
      logic                 load_off;
      logic [DataWidth-1:0] load_value;
   } cfg_type;

   typedef struct packed {
      logic                 step_taken;
      logic                 step_increase;
      logic [DataWidth-1:0] on_time_ms;
      logic [DataWidth-1:0] off_time_ms;
      logic                 transition_bad;
      logic                 sample_ignored;
   } result_type;

   // Quadrature delta for previous state -> new state, 2-bit signed.
   // Zero marks an illegal (diagonal) or null move.
   function automatic logic signed [1:0] quad_delta(input logic [1:0] prev,
                                                    input logic [1:0] pins);
      logic signed [1:0] d;
      d = 2'sd0;
      case ({prev, pins})
         4'b00_01, 4'b01_11, 4'b10_00, 4'b11_10: d = 2'sd1;
         4'b00_10, 4'b01_00, 4'b10_11, 4'b11_01: d = -2'sd1;
         default:                                 d = 2'sd0;
      endcase
      return d;
   endfunction

endpackage

FILE: hw/rtl/qdva_csr.sv
// Configuration registers and working-value load strobes.
// Depends on qdva_pkg.
module qdva_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [qdva_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [qdva_pkg::DataWidth-1:0]     csr_wdata,
   output qdva_pkg::cfg_type                  cfg
);
   import qdva_pkg::*;

   logic                 adjust_mode_ff, adjust_mode_in;
   logic [DataWidth-1:0] step_ff, step_in;
   logic [DataWidth-1:0] min_ff, min_in;
   logic [DataWidth-1:0] max_ff, max_in;
   logic [GapWidth-1:0]  gap_ff, gap_in;
   logic                 load_on, load_off;

   always_comb begin
      adjust_mode_in = adjust_mode_ff;
      step_in        = step_ff;
      min_in         = min_ff;
      max_in         = max_ff;
      gap_in         = gap_ff;
      load_on        = 1'b0;
      load_off       = 1'b0;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            REG_ADJUST_MODE:  adjust_mode_in = csr_wdata[0];
            REG_STEP_MS:      step_in        = csr_wdata;
            REG_MIN_MS:       min_in         = csr_wdata;
            REG_MAX_MS:       max_in         = csr_wdata;
            REG_EVENT_GAP_MS: gap_in         = csr_wdata[GapWidth-1:0];
            REG_START_ON_MS:  load_on        = 1'b1;
            REG_START_OFF_MS: load_off       = 1'b1;
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adjust_mode_ff <= 1'b0;
         step_ff        <= StepReset;
         min_ff         <= MinReset;
         max_ff         <= MaxReset;
         gap_ff         <= GapReset;
      end else begin
         adjust_mode_ff <= adjust_mode_in;
         step_ff        <= step_in;
         min_ff         <= min_in;
         max_ff         <= max_in;
         gap_ff         <= gap_in;
      end
   end

   assign cfg.adjust_mode  = adjust_mode_ff;
   assign cfg.step_ms      = step_ff;
   assign cfg.min_ms       = min_ff;
   assign cfg.max_ms       = max_ff;
   assign cfg.event_gap_ms = gap_ff;
   assign cfg.load_on      = load_on;
   assign cfg.load_off     = load_off;
   assign cfg.load_value   = csr_wdata;

endmodule

FILE: hw/rtl/qdva_core.sv
// Encoder state, transition decode, detent counting and clamped stepping.
// Depends on qdva_pkg.
module qdva_core #(
   parameter int unsigned DETENT_TRANSITIONS = qdva_pkg::DefaultDetentTransitions
) (
   input  logic                               clock,
   input  logic                               reset,
   input  qdva_pkg::cfg_type                  cfg,
   input  logic                               fire,
   input  logic                               pin_a,
   input  logic                               pin_b,
   input  logic [qdva_pkg::TimeWidth-1:0]     now_ms,
   output qdva_pkg::result_type               result
);
   import qdva_pkg::*;

   localparam logic signed [CountWidth-1:0] DetentPos = CountWidth'(DETENT_TRANSITIONS);
   localparam logic signed [CountWidth-1:0] DetentNeg = -DetentPos;
   localparam int unsigned WideWidth = DataWidth + 2;

   logic [1:0]                   prev_pins_ff, prev_pins_in;
   logic signed [CountWidth-1:0] count_ff, count_in;
   logic [TimeWidth-1:0]         last_time_ff, last_time_in;
   logic [DataWidth-1:0]         on_ff, on_in;
   logic [DataWidth-1:0]         off_ff, off_in;

   logic [1:0]                   pins;
   logic [TimeWidth-1:0]         elapsed;
   logic                         ignored, bad, hit, up;
   logic signed [1:0]            delta;
   logic signed [CountWidth-1:0] count_sum;
   logic [DataWidth-1:0]         selected, stepped;
   logic signed [WideWidth-1:0]  wide_val, wide_step, wide_next, wide_min, wide_max;

   always_comb begin
      pins      = {pin_a, pin_b};
      elapsed   = now_ms - last_time_ff;
      ignored   = (elapsed < TimeWidth'(cfg.event_gap_ms)) || (pins == prev_pins_ff);
      delta     = quad_delta(prev_pins_ff, pins);
      bad       = !ignored && (delta == 2'sd0);
      count_sum = count_ff - CountWidth'(delta);
      hit       = !ignored && !bad && ((count_sum >= DetentPos) || (count_sum <= DetentNeg));
      up        = count_sum > 0;

      // Step in wide signed arithmetic, then clamp: low bound wins first.
      selected  = cfg.adjust_mode ? off_ff : on_ff;
      wide_val  = $signed({2'b00, selected});
      wide_step = $signed({2'b00, cfg.step_ms});
      wide_min  = $signed({2'b00, cfg.min_ms});
      wide_max  = $signed({2'b00, cfg.max_ms});
      wide_next = up ? wide_val + wide_step : wide_val - wide_step;
      if (wide_next < wide_min)      stepped = cfg.min_ms;
      else if (wide_next > wide_max) stepped = cfg.max_ms;
      else                           stepped = wide_next[DataWidth-1:0];

      prev_pins_in = prev_pins_ff;
      count_in     = count_ff;
      last_time_in = last_time_ff;
      on_in        = on_ff;
      off_in       = off_ff;
      if (fire && !ignored) begin
         prev_pins_in = pins;
         last_time_in = now_ms;
         if (!bad) count_in = hit ? '0 : count_sum;
         if (hit) begin
            if (cfg.adjust_mode) off_in = stepped;
            else                 on_in  = stepped;
         end
      end
      if (cfg.load_on)  on_in  = cfg.load_value;
      if (cfg.load_off) off_in = cfg.load_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pins_ff <= PinsReset;
         count_ff     <= '0;
         last_time_ff <= '0;
         on_ff        <= StartReset;
         off_ff       <= StartReset;
      end else begin
         prev_pins_ff <= prev_pins_in;
         count_ff     <= count_in;
         last_time_ff <= last_time_in;
         on_ff        <= on_in;
         off_ff       <= off_in;
      end
   end

   // Result carries the values as they stand after this item.
   assign result.step_taken     = hit;
   assign result.step_increase  = hit && up;
   assign result.on_time_ms     = (hit && !cfg.adjust_mode) ? stepped : on_ff;
   assign result.off_time_ms    = (hit && cfg.adjust_mode) ? stepped : off_ff;
   assign result.transition_bad = bad;
   assign result.sample_ignored = ignored;

endmodule

FILE: hw/rtl/quadrature_detent_value_adjuster_top.sv
// Top level of the quadrature detent value adjuster: input register,
// result register and handshakes. Depends on qdva_pkg, qdva_csr, qdva_core.
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_ready | pin_a, pin_b, now_ms
//   rsp_    | out       | rsp_valid/rsp_ready | step_taken, step_increase, on/off time,
//           |           |                     | transition_bad, sample_ignored
//   csr_    | in        | csr_write_en        | csr_index, csr_wdata
//
// An item waits in the input register until the result register is free or
// draining; the decode, count and clamp update the encoder state at the edge
// that moves it into the result register, where its result is presented.
// One item per cycle is sustained while rsp_ready does not stall the result;
// each item reads the state the previous one left.
// Reset clears both register valids and returns all state to its defaults.
// A stalled result holds the input register, which then holds req_ready low.
module quadrature_detent_value_adjuster_top #(
   parameter int unsigned DETENT_TRANSITIONS = qdva_pkg::DefaultDetentTransitions
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_pin_a,
   input  logic                             req_pin_b,
   input  logic [qdva_pkg::TimeWidth-1:0]   req_now_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_step_taken,
   output logic                             rsp_step_increase,
   output logic [qdva_pkg::DataWidth-1:0]   rsp_on_time_ms,
   output logic [qdva_pkg::DataWidth-1:0]   rsp_off_time_ms,
   output logic                             rsp_transition_bad,
   output logic                             rsp_sample_ignored,
   input  logic                             csr_write_en,
   input  logic [qdva_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [qdva_pkg::DataWidth-1:0]   csr_wdata
);
   import qdva_pkg::*;

   cfg_type              cfg;
   result_type           result;

   logic                 in_valid_ff, in_valid_in;
   logic                 pin_a_ff, pin_b_ff;
   logic [TimeWidth-1:0] now_ff;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_ff;
   logic                 fire, take;

   // Advance the held item whenever the result slot is free or draining.
   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign take      = req_valid && req_ready;

   assign in_valid_in  = take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && !rsp_ready);

   qdva_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   qdva_core #(
      .DETENT_TRANSITIONS (DETENT_TRANSITIONS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (fire),
      .pin_a  (pin_a_ff),
      .pin_b  (pin_b_ff),
      .now_ms (now_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on handshake, hold otherwise.
   always_ff @(posedge clock) begin
      if (take) begin
         pin_a_ff <= req_pin_a;
         pin_b_ff <= req_pin_b;
         now_ff   <= req_now_ms;
      end
      if (fire) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_step_taken     = out_ff.step_taken;
   assign rsp_step_increase  = out_ff.step_increase;
   assign rsp_on_time_ms     = out_ff.on_time_ms;
   assign rsp_off_time_ms    = out_ff.off_time_ms;
   assign rsp_transition_bad = out_ff.transition_bad;
   assign rsp_sample_ignored = out_ff.sample_ignored;

endmodule

FILE: test/qdva_detent_checker.sv
// Checker for the quadrature detent value adjuster: mirrors the register file,
// predicts one result per accepted poll and compares results in order.
// Depends on qdva_pkg.
module qdva_detent_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             req_pin_a,
   input  logic                             req_pin_b,
   input  logic [qdva_pkg::TimeWidth-1:0]   req_now_ms,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic                             rsp_step_taken,
   input  logic                             rsp_step_increase,
   input  logic [qdva_pkg::DataWidth-1:0]   rsp_on_time_ms,
   input  logic [qdva_pkg::DataWidth-1:0]   rsp_off_time_ms,
   input  logic                             rsp_transition_bad,
   input  logic                             rsp_sample_ignored,
   input  logic                             csr_write_en,
   input  logic [qdva_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [qdva_pkg::DataWidth-1:0]   csr_wdata,
   output int                               mismatch_count,
   output int                               awaited_count,
   output int                               steps_seen,
   output int                               bad_seen,
   output int                               ignored_seen
);
   import qdva_pkg::*;

   localparam int DetentLimit = DefaultDetentTransitions;

   // Encoder delta indexed [previous pins][new pins]; zero is a diagonal or null move.
   localparam int QuadMove [4][4] = '{
      '{ 0,  1, -1,  0},
      '{-1,  0,  0,  1},
      '{ 1,  0,  0, -1},
      '{ 0, -1,  1,  0}
   };

   logic                 adjust_off;
   logic [DataWidth-1:0] step_size;
   logic [DataWidth-1:0] floor_ms;
   logic [DataWidth-1:0] ceiling_ms;
   logic [GapWidth-1:0]  gap_ms;
   logic [1:0]           last_pins;
   int                   travel;
   logic [TimeWidth-1:0] last_move_ms;
   logic [DataWidth-1:0] on_ms;
   logic [DataWidth-1:0] off_ms;
   result_type           awaited_results[$];
   int                   fails = 0;
   int                   checked = 0;

   // Step in wide signed arithmetic, then clamp; the lower bound is checked first.
   function automatic logic [DataWidth-1:0] clamp_step(logic [DataWidth-1:0] value, logic up);
      int stepped;
      stepped = up ? int'(value) + int'(step_size) : int'(value) - int'(step_size);
      if (stepped < int'(floor_ms))
         return floor_ms;
      if (stepped > int'(ceiling_ms))
         return ceiling_ms;
      return stepped[DataWidth-1:0];
   endfunction

   function automatic result_type predict_poll(logic [1:0] pins, logic [TimeWidth-1:0] stamp);
      result_type           r;
      logic [TimeWidth-1:0] elapsed;
      int                   delta;
      r = '0;
      elapsed = stamp - last_move_ms;
      if (elapsed < gap_ms || pins == last_pins) begin
         r.sample_ignored = 1'b1;
      end else begin
         delta = QuadMove[last_pins][pins];
         last_move_ms = stamp;
         last_pins = pins;
         if (delta == 0) begin
            r.transition_bad = 1'b1;
         end else begin
            travel -= delta;
            if (travel >= DetentLimit || travel <= -DetentLimit) begin
               r.step_taken = 1'b1;
               r.step_increase = travel > 0;
               travel = 0;
               if (adjust_off)
                  off_ms = clamp_step(off_ms, r.step_increase);
               else
                  on_ms = clamp_step(on_ms, r.step_increase);
            end
         end
      end
      r.on_time_ms = on_ms;
      r.off_time_ms = off_ms;
      return r;
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         adjust_off = 1'b0;
         step_size = StepReset;
         floor_ms = MinReset;
         ceiling_ms = MaxReset;
         gap_ms = GapReset;
         last_pins = PinsReset;
         travel = 0;
         last_move_ms = '0;
         on_ms = StartReset;
         off_ms = StartReset;
         awaited_results.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_ADJUST_MODE:  adjust_off = csr_wdata[0];
               REG_STEP_MS:      step_size = csr_wdata;
               REG_MIN_MS:       floor_ms = csr_wdata;
               REG_MAX_MS:       ceiling_ms = csr_wdata;
               REG_EVENT_GAP_MS: gap_ms = csr_wdata[GapWidth-1:0];
               REG_START_ON_MS:  on_ms = csr_wdata;
               REG_START_OFF_MS: off_ms = csr_wdata;
               default: ;
            endcase
         end
         // Pop before push: a result never belongs to the poll accepted at the same edge.
         if (rsp_valid && rsp_ready) begin
            got = {rsp_step_taken, rsp_step_increase, rsp_on_time_ms, rsp_off_time_ms,
                   rsp_transition_bad, rsp_sample_ignored};
            checked++;
            if (awaited_results.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("result %0d arrived with no poll outstanding", checked);
            end else begin
               want = awaited_results.pop_front();
               steps_seen += int'(want.step_taken);
               bad_seen += int'(want.transition_bad);
               ignored_seen += int'(want.sample_ignored);
               if (got !== want) begin
                  fails++;
                  if (fails <= 10)
                     $display({"result %0d mismatch: expected step=%0b up=%0b on=%0d off=%0d",
                               " bad=%0b ignored=%0b, got step=%0b up=%0b on=%0d off=%0d",
                               " bad=%0b ignored=%0b"}, checked,
                              want.step_taken, want.step_increase, want.on_time_ms,
                              want.off_time_ms, want.transition_bad, want.sample_ignored,
                              got.step_taken, got.step_increase, got.on_time_ms,
                              got.off_time_ms, got.transition_bad, got.sample_ignored);
               end
            end
         end
         if (req_valid && req_ready)
            awaited_results.push_back(predict_poll({req_pin_a, req_pin_b}, req_now_ms));
      end
      mismatch_count <= fails;
      awaited_count <= awaited_results.size();
   end

endmodule

FILE: test/quadrature_detent_value_adjuster_top_tb.sv
// Testbench top for the quadrature detent value adjuster: clock, reset, poll and
// register stimulus, and the verdict. Depends on qdva_pkg, the block and qdva_detent_checker.
module quadrature_detent_value_adjuster_top_tb;
   import qdva_pkg::*;

   // Index 7 decodes to no register; a write there must change nothing.
   localparam logic [CsrIdxWidth-1:0] UnusedCsrIndex = 3'd7;
   // Next pin state for one quarter turn: up walks 3,1,0,2 and down walks 3,2,0,1.
   localparam logic [1:0] UpNext   [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
   localparam logic [1:0] DownNext [4] = '{2'd1, 2'd3, 2'd0, 2'd2};
   localparam int PhaseCount    = 8;
   localparam int PollsPerPhase = 118;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_pin_a = 1'b1;
   logic                   req_pin_b = 1'b1;
   logic [TimeWidth-1:0]   req_now_ms = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_step_taken;
   logic                   rsp_step_increase;
   logic [DataWidth-1:0]   rsp_on_time_ms;
   logic [DataWidth-1:0]   rsp_off_time_ms;
   logic                   rsp_transition_bad;
   logic                   rsp_sample_ignored;
   logic                   csr_write_en = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [DataWidth-1:0]   csr_wdata = '0;

   int mismatch_count;
   int awaited_count;
   int steps_seen;
   int bad_seen;
   int ignored_seen;

   // Percentage of cycles in which each side holds off; zero for one whole phase.
   int                   stall_pct = 33;
   int                   polls_sent = 0;
   // Stimulus view of the encoder: pins last sent as a move, its time and a wall clock.
   logic [1:0]           pin_state = 2'b11;
   logic [TimeWidth-1:0] wall_ms = '0;
   logic [TimeWidth-1:0] moved_ms = '0;
   logic [GapWidth-1:0]  gap_ms = GapReset;
   logic                 turn_up = 1'b1;

   quadrature_detent_value_adjuster_top i_dut (.*);

   qdva_detent_checker i_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the result side at random, same rate as the poll side.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Offer one poll after a random hold-off; return in the step of its acceptance
   // with valid still high, so a back-to-back poll never drops it.
   task automatic send_poll(logic a, logic b, logic [TimeWidth-1:0] stamp);
      while ($urandom_range(0, 99) < stall_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pin_a <= a;
      req_pin_b <= b;
      req_now_ms <= stamp;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      polls_sent++;
   endtask

   // Drop valid and wait until every outstanding poll has its result, then let the
   // two-stage pipe drain before touching the registers.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(logic [CsrIdxWidth-1:0] idx, logic [DataWidth-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // Write every register; the unused upper bits of the narrow ones carry noise.
   task automatic load_settings(logic mode, logic [DataWidth-1:0] step,
                                logic [DataWidth-1:0] lo, logic [DataWidth-1:0] hi,
                                logic [GapWidth-1:0] gap,
                                logic [DataWidth-1:0] on_start,
                                logic [DataWidth-1:0] off_start);
      logic [DataWidth-1:0] noise;
      noise = 16'($urandom_range(0, 65535));
      write_reg(REG_ADJUST_MODE, {noise[15:1], mode});
      write_reg(REG_STEP_MS, step);
      write_reg(REG_MIN_MS, lo);
      write_reg(REG_MAX_MS, hi);
      write_reg(REG_EVENT_GAP_MS, {noise[15:8], gap});
      write_reg(REG_START_ON_MS, on_start);
      write_reg(REG_START_OFF_MS, off_start);
      write_reg(UnusedCsrIndex, ~noise);
      @(posedge clock);
      csr_write_en <= 1'b0;
      gap_ms = gap;
   endtask

   initial begin
      logic [1:0]           pins;
      logic [TimeWidth-1:0] stamp;
      logic [DataWidth-1:0] lo;
      logic [DataWidth-1:0] hi;
      int                   pick;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed polls on the reset settings: gap 1, step 10, both values 100.
      send_poll(1'b1, 1'b1, 32'h0000_0000);  // inside the gap of time zero, pins unchanged
      send_poll(1'b0, 1'b1, 32'h0000_0000);  // pins changed but inside the gap
      send_poll(1'b1, 1'b1, 32'h0000_0005);  // pins unchanged
      send_poll(1'b0, 1'b1, 32'h0000_000A);  // four quarter turns up
      send_poll(1'b0, 1'b0, 32'h0000_000B);  // exactly one gap later
      send_poll(1'b1, 1'b0, 32'h0000_000C);
      send_poll(1'b1, 1'b1, 32'h0000_000D);  // detent: on-time steps up
      send_poll(1'b1, 1'b0, 32'h0000_0014);  // four quarter turns down
      send_poll(1'b0, 1'b0, 32'h0000_0015);
      send_poll(1'b0, 1'b1, 32'h0000_0016);
      send_poll(1'b1, 1'b1, 32'h0000_0017);  // detent: on-time steps down
      send_poll(1'b0, 1'b0, 32'h0000_001E);  // diagonal jump
      send_poll(1'b1, 1'b1, 32'h0000_001F);  // diagonal jump back
      send_poll(1'b0, 1'b1, 32'hFFFF_FFF0);  // turns up across the timestamp wrap
      send_poll(1'b0, 1'b0, 32'hFFFF_FFFC);
      send_poll(1'b1, 1'b0, 32'h0000_0003);
      send_poll(1'b1, 1'b0, 32'h0000_0003);  // repeat of the same poll
      send_poll(1'b1, 1'b1, 32'h8000_0000);  // detent after the wrap
      send_poll(1'b0, 1'b1, 32'h8000_0000);  // change inside the gap
      send_poll(1'b0, 1'b1, 32'h8000_0001);  // one step up, then back down
      send_poll(1'b1, 1'b1, 32'h8000_0002);
      pin_state = 2'b11;
      wall_ms = 32'h8000_0002;
      moved_ms = wall_ms;

      for (int phase = 0; phase < PhaseCount; phase++) begin
         settle();
         stall_pct = (phase == 4) ? 0 : 33;
         case (phase)
            0: load_settings(1'b0, 16'd10, 16'd0, 16'hFFFF, 8'd1,
                             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            // Full-scale steps: every detent hits a bound; the gap check is off, then at its widest.
            1: load_settings(1'b1, 16'hFFFF, 16'd0, 16'hFFFF, 8'd0, 16'hFFFF, 16'd0);
            2: load_settings(1'b0, 16'hFFFF, 16'd0, 16'hFFFF, 8'd255, 16'd0, 16'hFFFF);
            // Inverted bounds: min above max.
            3: load_settings(1'($urandom_range(0, 1)), 16'($urandom_range(1, 3000)),
                             16'd40000, 16'd1000, 8'd3,
                             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            // Zero step: a detent only pulls the value into the bounds.
            4: load_settings(1'b1, 16'd0, 16'd20000, 16'd30000, 8'd2,
                             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            default: begin
               lo = 16'($urandom_range(0, 30000));
               hi = 16'($urandom_range(int'(lo), 65535));
               load_settings(1'($urandom_range(0, 1)), 16'($urandom_range(1, 6000)), lo, hi,
                             8'($urandom_range(0, 40)),
                             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            end
         endcase

         // Mostly clean quarter-turn runs that reverse now and then, plus repeats,
         // polls inside the gap, diagonal jumps and wild timestamps.
         repeat (PollsPerPhase) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               if ($urandom_range(0, 99) < 12)
                  turn_up = ~turn_up;
               pins = turn_up ? UpNext[pin_state] : DownNext[pin_state];
               wall_ms += 32'(gap_ms) + $urandom_range(0, 40);
               stamp = wall_ms;
               pin_state = pins;
               moved_ms = stamp;
            end else if (pick < 78) begin
               wall_ms += $urandom_range(0, 40);
               pins = pin_state;
               stamp = wall_ms;
            end else if (pick < 86 && gap_ms != 0) begin
               // Keep the encoder view: this change is meant to be dropped.
               pins = UpNext[pin_state];
               stamp = moved_ms + $urandom_range(0, int'(gap_ms) - 1);
            end else if (pick < 93) begin
               pins = ~pin_state;
               wall_ms += 32'(gap_ms) + $urandom_range(0, 40);
               stamp = wall_ms;
               pin_state = pins;
               moved_ms = stamp;
            end else begin
               pins = 2'($urandom_range(0, 3));
               wall_ms = $urandom();
               stamp = wall_ms;
               pin_state = pins;
               moved_ms = stamp;
            end
            send_poll(pins[1], pins[0], stamp);
         end
      end

      settle();
      $display("covered %0d polls under %0d register settings, reset values through",
               polls_sent, PhaseCount + 1);
      $display("full-scale steps, zero gap and inverted bounds: %0d detents, %0d diagonals, %0d rejected",
               steps_seen, bad_seen, ignored_seen);
      if (mismatch_count == 0 && awaited_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Hard stop far beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
